// ===== design/sbr_pkg.sv =====
`timescale 1ns / 1ps

package sbr_pkg;

	// Pipeline depth of the square root and of the divider, one result bit per stage.
	localparam int SQ_STAGES = 31;
	localparam int DIV_STAGES = 31;

	// Cycles from an accepted item to its done strobe.
	localparam int LATENCY = 2 + SQ_STAGES + DIV_STAGES + 9 + 1;

	// Reset value of the sphere radius register, 2.0 in Q7.16.
	localparam logic [22:0] RADIUS_RESET = 23'd131072;

	typedef struct packed {
		logic signed [23:0] cur_x;
		logic signed [23:0] cur_y;
		logic signed [23:0] cur_z;
		logic signed [23:0] prev_x;
		logic signed [23:0] prev_y;
		logic signed [23:0] prev_z;
		logic [22:0]        body_radius;
	} in_t;

	typedef struct packed {
		logic signed [23:0] new_cur_x;
		logic signed [23:0] new_cur_y;
		logic signed [23:0] new_cur_z;
		logic signed [23:0] new_prev_x;
		logic signed [23:0] new_prev_y;
		logic signed [23:0] new_prev_z;
		logic               hit_wall;
	} out_t;

	// Data that rides along with an item through the long units.
	typedef struct packed {
		logic signed [23:0] cx;
		logic signed [23:0] cy;
		logic signed [23:0] cz;
		logic signed [23:0] px;
		logic signed [23:0] py;
		logic signed [23:0] pz;
		logic signed [23:0] lim;
		logic               hit;
	} pass_t;

	typedef struct packed {
		logic        vld;
		logic [61:0] x;
		pass_t       pass;
	} sq_req_t;

	typedef struct packed {
		logic        vld;
		logic [30:0] root;
		pass_t       pass;
	} sq_rsp_t;

	typedef struct packed {
		logic        vld;
		logic [30:0] qx;
		logic [30:0] qy;
		logic [30:0] qz;
		pass_t       pass;
	} div_rsp_t;

endpackage

// ===== design/sphere_boundary_reflect.sv =====
`timescale 1ns / 1ps

// Keeps a Verlet particle inside a bounding sphere centered at the origin.
// Input channel: item carries current and previous position and the particle
// radius; an item is accepted at a rising edge with start high and busy low.
// busy is always low, so one item may be accepted in every cycle.
// Output channel: result is valid for exactly one cycle while done is high;
// the receiver takes it at the edge that ends that cycle and cannot stall.
// Configuration: wr_en with wr_data writes the sphere radius (Q7.16) at a
// rising edge; write it only while no item is in flight.
// On its way from start to done an item passes the 31-stage square root,
// the 31-stage divider for the normal and the multiply and round stages that
// follow. Throughput is one item per cycle.
// Reset clears all valid bits, so nothing in flight is delivered, and sets the
// sphere radius to 2.0.
module sphere_boundary_reflect (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  sbr_pkg::in_t  item,
	output logic          done,
	output sbr_pkg::out_t result,
	input  logic          wr_en,
	input  logic [22:0]   wr_data
);

	// Round half away from zero of x / 2^30.
	function automatic logic signed [63:0] rshr30(input logic signed [63:0] x);
		logic [63:0] mag;
		mag = x[63] ? 64'(-x) : 64'(x);
		mag = (mag + (64'd1 << 29)) >> 30;
		return x[63] ? -$signed(mag) : $signed(mag);
	endfunction

	// Clamp to the signed 24-bit range.
	function automatic logic signed [23:0] sat24(input logic signed [63:0] x);
		if (x > 64'sd8388607) begin
			return 24'sh7FFFFF;
		end else if (x < -64'sd8388608) begin
			return 24'sh800000;
		end
		return x[23:0];
	endfunction

	logic [22:0] radius_q;

	logic                vld_s1, vld_s2;
	logic                vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic                vld_s11;
	sbr_pkg::pass_t      pass_s1, pass_s2;
	sbr_pkg::pass_t      pass_s3, pass_s4, pass_s5, pass_s6, pass_s7, pass_s8, pass_s9;
	sbr_pkg::pass_t      pass_s10, pass_s11;
	logic [46:0]         sq_s1 [3];
	logic [46:0]         lim2_s1;
	logic [47:0]         d2_s2;
	logic signed [31:0]  n_s3 [3], n_s4 [3], n_s5 [3], n_s6 [3], n_s7 [3], n_s8 [3];
	logic signed [31:0]  n_s9 [3];
	logic signed [55:0]  prod_s4 [3];
	logic signed [23:0]  nc_s5 [3], nc_s6 [3], nc_s7 [3], nc_s8 [3], nc_s9 [3], nc_s10 [3];
	logic signed [23:0]  nc_s11 [3];
	logic signed [24:0]  v_s6 [3];
	logic signed [56:0]  nv_s7 [3];
	logic signed [58:0]  dot_s8;
	logic signed [29:0]  dq_s9;
	logic signed [62:0]  t_s10 [3];
	logic signed [23:0]  np_s11 [3];

	sbr_pkg::sq_req_t    sq_req;
	sbr_pkg::sq_rsp_t    sq_rsp;
	sbr_pkg::div_rsp_t   div_rsp;
	logic signed [23:0]  in_c [3];
	logic signed [23:0]  p_s5 [3];
	logic [30:0]         q_div [3];
	logic signed [23:0]  c_div [3];
	logic [47:0]         d2_sum;
	sbr_pkg::pass_t      pass_hit;

	assign busy = 1'b0;

	// Sphere radius register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= sbr_pkg::RADIUS_RESET;
		end else if (wr_en) begin
			radius_q <= wr_data;
		end
	end

	// Valid bits of the arithmetic stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			done    <= 1'b0;
		end else begin
			vld_s1  <= start && !busy;
			vld_s2  <= vld_s1;
			vld_s3  <= div_rsp.vld;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			done    <= vld_s11;
		end
	end

	assign in_c[0] = item.cur_x;
	assign in_c[1] = item.cur_y;
	assign in_c[2] = item.cur_z;

	// Stage 1: squares of the position and of the inner limit.
	always_ff @(posedge clk) begin
		pass_s1.cx  <= item.cur_x;
		pass_s1.cy  <= item.cur_y;
		pass_s1.cz  <= item.cur_z;
		pass_s1.px  <= item.prev_x;
		pass_s1.py  <= item.prev_y;
		pass_s1.pz  <= item.prev_z;
		pass_s1.lim <= $signed({1'b0, radius_q}) - $signed({1'b0, item.body_radius});
		pass_s1.hit <= 1'b0;
		lim2_s1     <= 47'($signed({1'b0, radius_q}) - $signed({1'b0, item.body_radius}))
			* 47'($signed({1'b0, radius_q}) - $signed({1'b0, item.body_radius}));
		for (int i = 0; i < 3; i++) begin
			sq_s1[i] <= 47'(48'(in_c[i]) * 48'(in_c[i]));
		end
	end

	// Squared distance and the wall test ahead of stage 2.
	assign d2_sum = {1'b0, sq_s1[0]} + {1'b0, sq_s1[1]} + {1'b0, sq_s1[2]};

	always_comb begin
		pass_hit     = pass_s1;
		pass_hit.hit = d2_sum > {1'b0, lim2_s1};
	end

	// Stage 2: squared distance and the wall test.
	always_ff @(posedge clk) begin
		d2_s2   <= d2_sum;
		pass_s2 <= pass_hit;
	end

	// Distance in Q.23, then the normal components.
	assign sq_req.vld  = vld_s2;
	assign sq_req.x    = {d2_s2, 14'd0};
	assign sq_req.pass = pass_s2;

	sbr_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sq_req),
		.rsp    (sq_rsp)
	);

	sbr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sq_rsp),
		.rsp    (div_rsp)
	);

	assign q_div[0] = div_rsp.qx;
	assign q_div[1] = div_rsp.qy;
	assign q_div[2] = div_rsp.qz;
	assign c_div[0] = div_rsp.pass.cx;
	assign c_div[1] = div_rsp.pass.cy;
	assign c_div[2] = div_rsp.pass.cz;

	assign p_s5[0] = pass_s5.px;
	assign p_s5[1] = pass_s5.py;
	assign p_s5[2] = pass_s5.pz;

	// Stages 3 to 11: signed normal, projection, velocity mirror.
	always_ff @(posedge clk) begin
		pass_s3  <= div_rsp.pass;
		pass_s4  <= pass_s3;
		pass_s5  <= pass_s4;
		pass_s6  <= pass_s5;
		pass_s7  <= pass_s6;
		pass_s8  <= pass_s7;
		pass_s9  <= pass_s8;
		pass_s10 <= pass_s9;
		pass_s11 <= pass_s10;
		dot_s8   <= 59'(nv_s7[0]) + 59'(nv_s7[1]) + 59'(nv_s7[2]);
		dq_s9    <= 30'(rshr30(64'(dot_s8)));
		for (int i = 0; i < 3; i++) begin
			n_s3[i]    <= c_div[i][23] ? -$signed({1'b0, q_div[i]}) : $signed({1'b0, q_div[i]});
			n_s4[i]    <= n_s3[i];
			prod_s4[i] <= 56'(n_s3[i]) * 56'(pass_s3.lim);
			n_s5[i]    <= n_s4[i];
			nc_s5[i]   <= sat24(rshr30(64'(prod_s4[i])));
			n_s6[i]    <= n_s5[i];
			nc_s6[i]   <= nc_s5[i];
			v_s6[i]    <= 25'(nc_s5[i]) - 25'(p_s5[i]);
			n_s7[i]    <= n_s6[i];
			nc_s7[i]   <= nc_s6[i];
			nv_s7[i]   <= 57'(n_s6[i]) * 57'(v_s6[i]);
			n_s8[i]    <= n_s7[i];
			nc_s8[i]   <= nc_s7[i];
			n_s9[i]    <= n_s8[i];
			nc_s9[i]   <= nc_s8[i];
			nc_s10[i]  <= nc_s9[i];
			t_s10[i]   <= {62'(62'(dq_s9) * 62'(n_s9[i])), 1'b0};
			nc_s11[i]  <= nc_s10[i];
		end
		np_s11[0] <= sat24(64'(pass_s10.px) + rshr30(64'(t_s10[0])));
		np_s11[1] <= sat24(64'(pass_s10.py) + rshr30(64'(t_s10[1])));
		np_s11[2] <= sat24(64'(pass_s10.pz) + rshr30(64'(t_s10[2])));
	end

	// Output register: corrected positions on a hit, the item unchanged otherwise.
	always_ff @(posedge clk) begin
		if (pass_s11.hit) begin
			result.new_cur_x  <= nc_s11[0];
			result.new_cur_y  <= nc_s11[1];
			result.new_cur_z  <= nc_s11[2];
			result.new_prev_x <= np_s11[0];
			result.new_prev_y <= np_s11[1];
			result.new_prev_z <= np_s11[2];
		end else begin
			result.new_cur_x  <= pass_s11.cx;
			result.new_cur_y  <= pass_s11.cy;
			result.new_cur_z  <= pass_s11.cz;
			result.new_prev_x <= pass_s11.px;
			result.new_prev_y <= pass_s11.py;
			result.new_prev_z <= pass_s11.pz;
		end
		result.hit_wall <= pass_s11.hit;
	end

`ifndef NO_ASSERTIONS
	// Every accepted item comes out after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(sbr_pkg::LATENCY) done)
		else $error("item did not complete after the pipeline latency");

	// A wall hit never comes from a particle at the origin.
	a_hit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && pass_s2.hit |-> d2_s2 != 48'd0)
		else $error("wall hit with zero distance");

	// On a hit the distance is at least one Q7.16 step, so the divisor is large.
	a_root_floor: assert property (@(posedge clk) disable iff (!arst_n)
		sq_rsp.vld && sq_rsp.pass.hit |-> sq_rsp.root >= 31'd128)
		else $error("square root below the smallest hit distance");
`endif

endmodule

// ===== design/sbr_isqrt.sv =====
`timescale 1ns / 1ps

// Pipelined integer square root, two radicand bits and one root bit per stage.
module sbr_isqrt (
	input  logic             clk,
	input  logic             arst_n,
	input  sbr_pkg::sq_req_t req,
	output sbr_pkg::sq_rsp_t rsp
);

	localparam int NS = sbr_pkg::SQ_STAGES;

	logic               vld_s  [0:NS];
	logic [34:0]        rem_s  [0:NS];
	logic [30:0]        root_s [0:NS];
	logic [61:0]        x_s    [0:NS];
	sbr_pkg::pass_t     pass_s [0:NS];

	// Stage zero is the request itself.
	assign vld_s[0]  = req.vld;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign x_s[0]    = req.x;
	assign pass_s[0] = req.pass;

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [34:0] rem_sh;
		logic [34:0] trial;
		logic        ge;

		// Bring down the next bit pair and try the next root bit.
		always_comb begin
			rem_sh = {rem_s[k][32:0], x_s[k][61 - 2 * k -: 2]};
			trial  = {2'b00, root_s[k], 2'b01};
			ge     = rem_sh >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k + 1] <= 1'b0;
			end else begin
				vld_s[k + 1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k + 1]  <= ge ? rem_sh - trial : rem_sh;
			root_s[k + 1] <= {root_s[k][29:0], ge};
			x_s[k + 1]    <= x_s[k];
			pass_s[k + 1] <= pass_s[k];
		end
	end

	assign rsp.vld  = vld_s[NS];
	assign rsp.root = root_s[NS];
	assign rsp.pass = pass_s[NS];

endmodule

// ===== design/sbr_div.sv =====
`timescale 1ns / 1ps

// Three-lane pipelined restoring divider: |c| * 2^37 / s, rounded half up.
module sbr_div (
	input  logic              clk,
	input  logic              arst_n,
	input  sbr_pkg::sq_rsp_t  req,
	output sbr_pkg::div_rsp_t rsp
);

	localparam int ND = sbr_pkg::DIV_STAGES;

	logic               vld_s  [0:ND];
	logic [30:0]        s_s    [0:ND];
	logic [60:0]        num_s  [0:2][0:ND];
	logic [31:0]        rem_s  [0:2][0:ND];
	logic [30:0]        quo_s  [0:2][0:ND];
	sbr_pkg::pass_t     pass_s [0:ND];
	logic signed [23:0] coord  [0:2];

	assign coord[0] = req.pass.cx;
	assign coord[1] = req.pass.cy;
	assign coord[2] = req.pass.cz;

	assign vld_s[0]  = req.vld;
	assign s_s[0]    = req.root;
	assign pass_s[0] = req.pass;

	// Numerator with the rounding term; its top bits start the remainder.
	for (genvar l = 0; l < 3; l++) begin : g_lane0
		logic [23:0] mag;
		always_comb begin
			mag = coord[l][23] ? 24'(-coord[l]) : 24'(coord[l]);
		end
		assign num_s[l][0] = {mag, 37'd0} + {31'd0, req.root[30:1]};
		assign rem_s[l][0] = {2'b00, num_s[l][0][60:31]};
		assign quo_s[l][0] = '0;
	end

	for (genvar k = 0; k < ND; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k + 1] <= 1'b0;
			end else begin
				vld_s[k + 1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			s_s[k + 1]    <= s_s[k];
			pass_s[k + 1] <= pass_s[k];
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [31:0] t;
			logic        ge;

			// Shift in one numerator bit and subtract the divisor when it fits.
			always_comb begin
				t  = {rem_s[l][k][30:0], num_s[l][k][30 - k]};
				ge = t >= {1'b0, s_s[k]};
			end

			always_ff @(posedge clk) begin
				rem_s[l][k + 1] <= ge ? t - {1'b0, s_s[k]} : t;
				quo_s[l][k + 1] <= {quo_s[l][k][29:0], ge};
				num_s[l][k + 1] <= num_s[l][k];
			end
		end
	end

	assign rsp.vld  = vld_s[ND];
	assign rsp.qx   = quo_s[0][ND];
	assign rsp.qy   = quo_s[1][ND];
	assign rsp.qz   = quo_s[2][ND];
	assign rsp.pass = pass_s[ND];

endmodule

// ===== test/sbr_checker.sv =====
`timescale 1ns / 1ps

module sbr_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  sbr_pkg::in_t  item,
	input  logic          done,
	input  sbr_pkg::out_t result,
	input  logic          wr_en,
	input  logic [22:0]   wr_data,
	output int            fail_count,
	output int            pending
);

	logic [22:0]   radius_q;
	sbr_pkg::out_t expected_q[$];

	// Clamps a value to the signed 24-bit range.
	function automatic logic signed [23:0] clamp24(input longint v);
		if (v > 64'sd8388607) return 24'sh7FFFFF;
		if (v < -64'sd8388608) return 24'sh800000;
		return v[23:0];
	endfunction

	// Divides by a power of two, rounding half away from zero.
	function automatic longint round_shift(input longint x, input int sh);
		longint mag;
		mag = (x < 0) ? -x : x;
		mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
		return (x < 0) ? -mag : mag;
	endfunction

	// Integer square root, floor.
	function automatic longint floor_sqrt(input logic [63:0] x);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return longint'(res);
	endfunction

	// Projects a particle onto the inner limit and mirrors its velocity.
	function automatic sbr_pkg::out_t reflect_particle(input sbr_pkg::in_t it,
		input logic [22:0] rad);
		sbr_pkg::out_t o;
		longint c[3], p[3], nrm[3], nc[3], np[3];
		longint lim, d2, dotv, dq, s, mag;
		logic   hit;
		c[0] = it.cur_x;  c[1] = it.cur_y;  c[2] = it.cur_z;
		p[0] = it.prev_x; p[1] = it.prev_y; p[2] = it.prev_z;
		lim = longint'(rad) - longint'(it.body_radius);
		d2 = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
		hit = d2 > lim * lim;
		for (int i = 0; i < 3; i++) begin
			nc[i] = c[i];
			np[i] = p[i];
		end
		if (hit) begin
			s = floor_sqrt(64'(d2) << 14);
			for (int i = 0; i < 3; i++) begin
				mag = (c[i] < 0) ? -c[i] : c[i];
				mag = ((mag << 37) + s / 2) / s;
				nrm[i] = (c[i] < 0) ? -mag : mag;
				nc[i] = clamp24(round_shift(nrm[i] * lim, 30));
			end
			dotv = 0;
			for (int i = 0; i < 3; i++) dotv += nrm[i] * (nc[i] - p[i]);
			dq = round_shift(dotv, 30);
			for (int i = 0; i < 3; i++)
				np[i] = clamp24(p[i] + round_shift(2 * dq * nrm[i], 30));
		end
		o.new_cur_x = 24'(nc[0]);  o.new_cur_y = 24'(nc[1]);  o.new_cur_z = 24'(nc[2]);
		o.new_prev_x = 24'(np[0]); o.new_prev_y = 24'(np[1]); o.new_prev_z = 24'(np[2]);
		o.hit_wall = hit;
		return o;
	endfunction

	assign pending = expected_q.size();

	// Track the radius register, predict accepted items and compare results.
	always @(posedge clk or negedge arst_n) begin
		sbr_pkg::out_t exp_r;
		if (!arst_n) begin
			radius_q <= sbr_pkg::RADIUS_RESET;
			expected_q.delete();
			fail_count <= 0;
		end else begin
			if (wr_en) radius_q <= wr_data;
			if (start && !busy) expected_q = {expected_q, reflect_particle(item, radius_q)};
			if (done) begin
				if (expected_q.size() == 0) begin
					if (fail_count < 10) $display("unexpected result %h", result);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = expected_q.pop_front();
					if (result !== exp_r) begin
						if (fail_count < 10)
							$display("mismatch: expected %h actual %h", exp_r, result);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// ===== test/tb_sphere_boundary_reflect.sv =====
`timescale 1ns / 1ps

module tb_sphere_boundary_reflect;

	localparam int STALL_LIMIT = 20 * sbr_pkg::LATENCY + 2000;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic          busy;
	sbr_pkg::in_t  item = '0;
	logic          done;
	sbr_pkg::out_t result;
	logic          wr_en = 1'b0;
	logic [22:0]   wr_data = '0;
	int            fail_count;
	int            pending;
	int            idle_pct = 0;
	int            quiet_cycles = 0;

	sphere_boundary_reflect DUT (.*);

	sbr_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on cycles without any accepted item or result.
	always @(posedge clk) begin
		if ((start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic signed [23:0] rand_coord(input int mode);
		case (mode)
			0: return 24'($urandom);
			1: return $signed(24'($urandom_range(0, 262143))) - 24'sd131072;
			default: return $signed(24'($urandom_range(0, 1048575))) - 24'sd524288;
		endcase
	endfunction

	// Sends one item, holding start until the block takes it.
	task automatic send_particle(input sbr_pkg::in_t it);
		while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		item <= it;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	// Writes the radius once the pipe has drained.
	task automatic set_radius(input logic [22:0] r);
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (sbr_pkg::LATENCY + 4) @(negedge clk);
		wr_en <= 1'b1;
		wr_data <= r;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic random_phase(input int count);
		sbr_pkg::in_t it;
		int           mode;
		for (int k = 0; k < count; k++) begin
			mode = $urandom_range(0, 2);
			it.cur_x = rand_coord(mode);
			it.cur_y = rand_coord(mode);
			it.cur_z = rand_coord(mode);
			it.prev_x = rand_coord(mode);
			it.prev_y = rand_coord(mode);
			it.prev_z = rand_coord(mode);
			it.body_radius = ($urandom_range(0, 7) == 0) ? 23'($urandom)
				: 23'($urandom_range(0, 65536));
			send_particle(it);
		end
	endtask

	initial begin
		sbr_pkg::in_t       it;
		logic signed [23:0] ext[4];
		ext[0] = 24'sh7FFFFF; ext[1] = 24'sh800000; ext[2] = 24'sd0; ext[3] = 24'sd65536;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: extremes, origin, inside, outside, limit not positive.
		for (int k = 0; k < 16; k++) begin
			it.cur_x = ext[k % 4];
			it.cur_y = ext[(k / 4) % 4];
			it.cur_z = ext[(k + 1) % 4];
			it.prev_x = ext[(k + 2) % 4];
			it.prev_y = ext[(k + 3) % 4];
			it.prev_z = ext[k / 4];
			it.body_radius = (k % 3 == 0) ? 23'h7FFFFF : ((k % 3 == 1) ? 23'd0 : 23'd131072);
			send_particle(it);
		end
		it = '0;
		send_particle(it);
		it.cur_x = 24'sd16384;
		it.body_radius = 23'd32768;
		send_particle(it);

		idle_pct = 25;
		random_phase(150);
		set_radius(23'h7FFFFF);
		random_phase(40);
		set_radius(23'd0);
		idle_pct = 56;
		random_phase(40);
		set_radius(23'd327680);
		random_phase(100);
		set_radius(23'($urandom_range(1, 8388607)));
		idle_pct = 0;
		random_phase(120);
		start <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (sbr_pkg::LATENCY + 10) @(negedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
